### rtl/core/fbgw_pkg.sv
// Shared types, constants, glyph tables and helpers for the packed RGB frame buffer glyph writer.
package fbgw_pkg;

    localparam int MAX_PANELS_DEF = 8;
    localparam int PANEL_SIDE     = 8;
    localparam int PANEL_PIXELS   = PANEL_SIDE * PANEL_SIDE;
    localparam int STORE_BYTES    = 768;
    localparam int PIX_W          = 12;
    localparam int WORD_W         = 2 * PIX_W;
    localparam int CNT_X_W        = 6;
    localparam int CNT_Y_W        = 4;

    typedef enum logic [1:0] {
        CMD_PAINT = 2'd0,
        CMD_GLYPH = 2'd1,
        CMD_FILL  = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd_code;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_BAD_CHAR = 2'd1,
        STS_DROPPED  = 2'd2
    } t_status;

    localparam logic CFG_SQUARE = 1'b0;
    localparam logic CFG_PANELS = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_BYTE_RD,
        ST_BYTE_SEL,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_cmd_code         cmd;
        logic signed [7:0] x_coord;
        logic signed [7:0] y_coord;
        logic [11:0]       pixel_color;
        logic [6:0]        char_code;
        logic [9:0]        byte_addr;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic [2:0] advance;
        t_status    status;
    } t_result;

    typedef struct packed {
        logic       square;
        logic [3:0] panels;
    } t_cfg;

    localparam logic [8:0] GLYPH_START [96] = '{
        9'd0,   9'd1,   9'd2,   9'd5,   9'd10,  9'd13,  9'd17,  9'd21,  9'd22,  9'd24,
        9'd26,  9'd31,  9'd34,  9'd36,  9'd38,  9'd39,  9'd43,  9'd46,  9'd49,  9'd52,
        9'd55,  9'd58,  9'd61,  9'd64,  9'd67,  9'd70,  9'd73,  9'd74,  9'd76,  9'd78,
        9'd80,  9'd82,  9'd85,  9'd88,  9'd91,  9'd94,  9'd97,  9'd100, 9'd103, 9'd106,
        9'd109, 9'd112, 9'd115, 9'd118, 9'd122, 9'd125, 9'd130, 9'd134, 9'd138, 9'd141,
        9'd145, 9'd148, 9'd151, 9'd154, 9'd158, 9'd162, 9'd167, 9'd170, 9'd173, 9'd177,
        9'd179, 9'd183, 9'd185, 9'd188, 9'd191, 9'd193, 9'd196, 9'd199, 9'd202, 9'd205,
        9'd208, 9'd210, 9'd212, 9'd215, 9'd216, 9'd219, 9'd222, 9'd224, 9'd229, 9'd232,
        9'd235, 9'd238, 9'd241, 9'd243, 9'd246, 9'd249, 9'd252, 9'd255, 9'd260, 9'd263,
        9'd266, 9'd269, 9'd272, 9'd273, 9'd276, 9'd280
    };

    localparam logic [7:0] GLYPH_ROWS [4][35] = '{
        '{8'h6a, 8'h9c, 8'hb5, 8'haa, 8'h00, 8'h29, 8'h6c, 8'h7b, 8'hff, 8'h90, 8'h33, 8'h59,
          8'hef, 8'hdd, 8'he6, 8'h64, 8'h65, 8'hb3, 8'h67, 8'he6, 8'h63, 8'h6f, 8'hf1, 8'ha1,
          8'h08, 8'h08, 8'h79, 8'h12, 8'h00, 8'h19, 8'h01, 8'h00, 8'h01, 8'h7b, 8'he0},
        '{8'h6f, 8'hf1, 8'h26, 8'h5c, 8'h80, 8'h57, 8'h17, 8'h64, 8'h3e, 8'hc7, 8'h8d, 8'hbe,
          8'h5d, 8'h25, 8'h46, 8'ha6, 8'hf6, 8'h6c, 8'hd8, 8'ha6, 8'h6a, 8'ha9, 8'h48, 8'hd0,
          8'hbc, 8'hdb, 8'hbc, 8'h36, 8'hd6, 8'h56, 8'hef, 8'hdb, 8'h1b, 8'hce, 8'hb5},
        '{8'h07, 8'hda, 8'h4a, 8'h5d, 8'hdc, 8'h95, 8'h43, 8'hcf, 8'h57, 8'h98, 8'h44, 8'hf6,
          8'h59, 8'haf, 8'h57, 8'ha5, 8'h6e, 8'h75, 8'he2, 8'ha5, 8'h77, 8'h52, 8'h44, 8'h80,
          8'h5b, 8'h2e, 8'hdb, 8'hba, 8'had, 8'hbb, 8'hc9, 8'h5b, 8'h54, 8'h52, 8'haa},
        '{8'h42, 8'hb4, 8'hb1, 8'haa, 8'ha3, 8'h0b, 8'hfc, 8'h77, 8'h9c, 8'he7, 8'h93, 8'hb9,
          8'hef, 8'h1d, 8'hea, 8'h7c, 8'h65, 8'ha3, 8'hdc, 8'h98, 8'ha3, 8'h57, 8'he3, 8'h8e,
          8'h3c, 8'hdb, 8'hbb, 8'h57, 8'had, 8'h51, 8'hd9, 8'h34, 8'hab, 8'hbb, 8'he0}
    };

    function automatic logic glyph_bit(input logic [1:0] row, input logic [8:0] bit_pos);
        logic [5:0] byte_i;
        logic [7:0] bits;
        byte_i = bit_pos[8:3];
        if (byte_i >= 6'd35) begin
            byte_i = byte_i - 6'd35;
        end
        bits = GLYPH_ROWS[row][byte_i];
        return bits[3'd7 - bit_pos[2:0]];
    endfunction

endpackage

### rtl/core/packed_rgb_framebuffer_glyph_writer.sv
// Top level: stream ports, configuration registers, result register and the command sequencer.
// One command at a time: a new beat is accepted only after the previous result is handed on.
// Glyph: each set in-window pixel is written by read-modify-write; other positions are skipped.
// Fill: every display pixel is written by the same read-modify-write loop; dropped ones are skipped.
// A result beat waits in its output register while the next command is accepted.
// After synchronous reset all MAX_PANELS*32 store words are zeroed with tready low.
module packed_rgb_framebuffer_glyph_writer
    import fbgw_pkg::*;
#(
    parameter int MAX_PANELS = MAX_PANELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // x_coord[7:0], y_coord[15:8], pixel_color[27:16], char_code[34:28], byte_addr[44:35].
    input  logic [47:0] i_s_axis_tdata,
    // cmd[1:0].
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // read_data[7:0], advance[10:8].
    output logic [15:0] o_m_axis_tdata,
    // status[1:0].
    output logic [1:0]  o_m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [3:0]  i_cfg_data
);

    logic       r_square;
    logic [3:0] r_panels;
    logic       r_out_valid;
    t_result    r_out;

    t_cfg       w_cfg;
    t_item      w_item;
    logic       w_item_ready;
    logic       w_res_valid;
    logic       w_res_ready;
    t_result    w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square <= 1'b0;
            r_panels <= 4'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SQUARE: r_square <= i_cfg_data[0];
                CFG_PANELS: r_panels <= i_cfg_data;
                default:    r_panels <= r_panels;
            endcase
        end
    end

    assign w_cfg.square = r_square;
    assign w_cfg.panels = (r_panels > 4'(MAX_PANELS)) ? 4'(MAX_PANELS) : r_panels;

    assign w_item.cmd         = t_cmd_code'(i_s_axis_tuser);
    assign w_item.x_coord     = i_s_axis_tdata[7:0];
    assign w_item.y_coord     = i_s_axis_tdata[15:8];
    assign w_item.pixel_color = i_s_axis_tdata[27:16];
    assign w_item.char_code   = i_s_axis_tdata[34:28];
    assign w_item.byte_addr   = i_s_axis_tdata[44:35];

    fbgw_ctrl #(
        .MAX_PANELS (MAX_PANELS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_item_valid (i_s_axis_tvalid),
        .o_item_ready (w_item_ready),
        .i_item       (w_item),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_ready),
        .o_res        (w_res)
    );

    assign o_s_axis_tready = w_item_ready;
    assign w_res_ready     = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out.advance, r_out.read_data};
    assign o_m_axis_tuser  = r_out.status;

    a_no_ready_after_reset: assert property (
        @(posedge i_clk) !i_rst_n |=> !o_s_axis_tready
    ) else $error("Input accepted right after reset, before the store was cleared.");

    a_one_item_at_a_time: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready
    ) else $error("A second beat was accepted while a command was in progress.");

    a_advance_only_for_glyph: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[10:8] != 3'd0))
            |-> ((o_m_axis_tdata[7:0] == 8'd0) && (o_m_axis_tuser != STS_BAD_CHAR))
    ) else $error("Result carries an advance together with read data or a bad character.");

endmodule

### rtl/core/fbgw_ram.sv
// Generic single-port synchronous RAM with registered read data.
module fbgw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/fbgw_pixel_map.sv
// Maps a pixel coordinate to a frame store word and half, with the layout remap and range check.
module fbgw_pixel_map
    import fbgw_pkg::*;
#(
    parameter int AW = 8
) (
    input  t_cfg              i_cfg,
    input  logic signed [8:0] i_x,
    input  logic signed [8:0] i_y,
    output logic              o_ok,
    output logic [AW-1:0]     o_word,
    output logic              o_half
);

    logic [9:0]  w_sx;
    logic [9:0]  w_sy;
    logic [9:0]  w_q;
    logic [15:0] w_panel;
    logic [15:0] w_row;
    logic [15:0] w_idx;
    logic [15:0] w_limit;

    always_comb begin
        if (i_cfg.square && (i_y < 9'sd8)) begin
            w_sx = 10'd31 - {i_x[8], i_x};
            w_sy = 10'd7 - {i_y[8], i_y};
        end else if (i_cfg.square) begin
            w_sx = {i_x[8], i_x} - 10'd8;
            w_sy = {i_y[8], i_y};
        end else begin
            w_sx = {i_x[8], i_x};
            w_sy = {i_y[8], i_y};
        end
        w_q     = {{3{w_sx[9]}}, w_sx[9:3]};
        w_panel = {12'd0, i_cfg.panels} - 16'd1 - {{6{w_q[9]}}, w_q};
        w_row   = 16'd7 - {{6{w_sy[9]}}, w_sy};
        w_idx   = {w_panel[9:0], 6'd0} + {w_row[12:0], 3'd0} + {13'd0, w_sx[2:0]};
        w_limit = {6'd0, i_cfg.panels, 6'd0};
    end

    assign o_ok   = !w_idx[15] && (w_idx < w_limit);
    assign o_word = w_idx[AW:1];
    assign o_half = w_idx[0];

endmodule

### rtl/core/fbgw_ctrl.sv
// Command sequencer: clearing pass, pixel read-modify-write loop, glyph and fill scans, byte reads.
module fbgw_ctrl
    import fbgw_pkg::*;
#(
    parameter int MAX_PANELS = MAX_PANELS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_item_valid,
    output logic    o_item_ready,
    input  t_item   i_item,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_res
);

    localparam int DEPTH = MAX_PANELS * PANEL_PIXELS / 2;
    localparam int AW    = $clog2(DEPTH);

    t_state               r_state, n_state;
    t_item                r_item, n_item;
    logic [CNT_X_W-1:0]   r_ca, n_ca, r_lim_a, n_lim_a;
    logic [CNT_Y_W-1:0]   r_cb, n_cb, r_lim_b, n_lim_b;
    logic [8:0]           r_gstart, n_gstart;
    logic [2:0]           r_adv, n_adv;
    logic                 r_drop, n_drop;
    logic                 r_bad, n_bad;
    logic [AW-1:0]        r_clr, n_clr;
    logic [AW-1:0]        r_word, n_word;
    logic                 r_half, n_half;
    logic [1:0]           r_bsel, n_bsel;
    logic                 r_bvalid, n_bvalid;
    logic [7:0]           r_rdata, n_rdata;

    logic                 w_take;
    logic [6:0]           w_disp_w;
    logic [4:0]           w_disp_h;
    logic                 w_bad_ch;
    logic [6:0]           w_gi;
    logic [8:0]           w_gs;
    logic [8:0]           w_ge;
    logic [2:0]           w_gw;
    logic signed [8:0]    w_xpt;
    logic signed [8:0]    w_ypt;
    logic                 w_clip_ok;
    logic                 w_draw;
    logic                 w_last;
    logic                 w_row_end;
    logic                 w_map_ok;
    logic [AW-1:0]        w_map_word;
    logic                 w_map_half;
    logic [19:0]          w_prod;
    logic [8:0]           w_q;
    logic [9:0]           w_rem;
    logic                 w_addr_ok;
    logic                 w_mem_we;
    logic [AW-1:0]        w_mem_addr;
    logic [WORD_W-1:0]    w_mem_wdata;
    logic [WORD_W-1:0]    w_mem_rdata;

    fbgw_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

    fbgw_pixel_map #(
        .AW (AW)
    ) u_map (
        .i_cfg  (i_cfg),
        .i_x    (w_xpt),
        .i_y    (w_ypt),
        .o_ok   (w_map_ok),
        .o_word (w_map_word),
        .o_half (w_map_half)
    );

    assign w_take   = i_item_valid && (r_state == ST_IDLE);
    assign w_disp_w = i_cfg.square ? 7'd16 : {i_cfg.panels, 3'd0};
    assign w_disp_h = i_cfg.square ? 5'd16 : 5'd8;

    assign w_bad_ch = (i_item.char_code < 7'd32) || (i_item.char_code > 7'd126);
    assign w_gi     = w_bad_ch ? 7'd0 : (i_item.char_code - 7'd32);
    assign w_gs     = GLYPH_START[w_gi];
    assign w_ge     = GLYPH_START[w_gi + 7'd1];
    assign w_gw     = 3'(w_ge - w_gs);

    always_comb begin
        unique case (r_item.cmd)
            CMD_GLYPH: begin
                w_xpt = {r_item.x_coord[7], r_item.x_coord} + {3'd0, r_ca};
                w_ypt = {r_item.y_coord[7], r_item.y_coord} + {5'd0, r_cb};
            end
            CMD_FILL: begin
                w_xpt = {3'd0, r_ca};
                w_ypt = {5'd0, r_cb};
            end
            default: begin
                w_xpt = {r_item.x_coord[7], r_item.x_coord};
                w_ypt = {r_item.y_coord[7], r_item.y_coord};
            end
        endcase
    end

    assign w_clip_ok = !w_xpt[8] && (w_xpt[7:0] < {1'b0, w_disp_w})
                    && !w_ypt[8] && (w_ypt[7:0] < {3'd0, w_disp_h});
    assign w_draw    = (r_item.cmd != CMD_GLYPH)
                    || (w_clip_ok && glyph_bit(r_cb[1:0], r_gstart + {3'd0, r_ca}));
    assign w_row_end = (r_ca == r_lim_a);
    assign w_last    = w_row_end && (r_cb == r_lim_b);

    assign w_prod    = {10'd0, r_item.byte_addr} * 20'd683;
    assign w_q       = w_prod[19:11];
    assign w_rem     = r_item.byte_addr - ({1'b0, w_q} + {w_q, 1'b0});
    assign w_addr_ok = (r_item.byte_addr < 10'(STORE_BYTES)) && ({1'b0, w_q} < 10'(DEPTH));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_take) begin
                    unique case (i_item.cmd)
                        CMD_PAINT: n_state = ST_PIX_RD;
                        CMD_GLYPH: n_state = w_bad_ch ? ST_DONE : ST_PIX_RD;
                        CMD_FILL:  n_state = (w_disp_w == 7'd0) ? ST_DONE : ST_PIX_RD;
                        default:   n_state = ST_BYTE_RD;
                    endcase
                end
            end
            ST_PIX_RD: begin
                if (w_draw && w_map_ok) begin
                    n_state = ST_PIX_WR;
                end else if (w_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_PIX_WR: n_state = w_last ? ST_DONE : ST_PIX_RD;
            ST_BYTE_RD: n_state = ST_BYTE_SEL;
            ST_BYTE_SEL: n_state = ST_DONE;
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and memory port.
    always_comb begin
        o_item_ready = 1'b0;
        o_res_valid  = 1'b0;
        w_mem_we     = 1'b0;
        w_mem_addr   = r_word;
        w_mem_wdata  = r_half ? {w_mem_rdata[WORD_W-1:PIX_W], r_item.pixel_color}
                              : {r_item.pixel_color, w_mem_rdata[PIX_W-1:0]};
        unique case (r_state)
            ST_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_addr  = r_clr;
                w_mem_wdata = '0;
            end
            ST_IDLE:     o_item_ready = 1'b1;
            ST_PIX_RD:   w_mem_addr = w_map_word;
            ST_PIX_WR:   w_mem_we = 1'b1;
            ST_BYTE_RD:  w_mem_addr = w_q[AW-1:0];
            ST_BYTE_SEL: w_mem_addr = r_word;
            ST_DONE:     o_res_valid = 1'b1;
            default:     o_item_ready = 1'b0;
        endcase
    end

    // Datapath registers.
    always_comb begin
        n_item   = r_item;
        n_ca     = r_ca;
        n_cb     = r_cb;
        n_lim_a  = r_lim_a;
        n_lim_b  = r_lim_b;
        n_gstart = r_gstart;
        n_adv    = r_adv;
        n_drop   = r_drop;
        n_bad    = r_bad;
        n_clr    = r_clr;
        n_word   = r_word;
        n_half   = r_half;
        n_bsel   = r_bsel;
        n_bvalid = r_bvalid;
        n_rdata  = r_rdata;
        case (r_state)
            ST_CLEAR: n_clr = r_clr + AW'(1);
            ST_IDLE: begin
                if (w_take) begin
                    n_item   = i_item;
                    n_ca     = '0;
                    n_cb     = '0;
                    n_lim_a  = '0;
                    n_lim_b  = '0;
                    n_gstart = w_gs;
                    n_adv    = 3'd0;
                    n_drop   = 1'b0;
                    n_bad    = 1'b0;
                    n_rdata  = 8'd0;
                    if (i_item.cmd == CMD_GLYPH) begin
                        n_bad = w_bad_ch;
                        if (!w_bad_ch) begin
                            n_lim_a = CNT_X_W'(w_gw - 3'd1);
                            n_lim_b = CNT_Y_W'(3);
                            n_adv   = w_gw + 3'd1;
                        end
                    end else if (i_item.cmd == CMD_FILL) begin
                        n_lim_a = CNT_X_W'(w_disp_w - 7'd1);
                        n_lim_b = CNT_Y_W'(w_disp_h - 5'd1);
                    end
                end
            end
            ST_PIX_RD, ST_PIX_WR: begin
                if ((r_state == ST_PIX_RD) && w_draw && w_map_ok) begin
                    n_word = w_map_word;
                    n_half = w_map_half;
                end else begin
                    if ((r_state == ST_PIX_RD) && w_draw) begin
                        n_drop = 1'b1;
                    end
                    if (w_row_end) begin
                        n_ca = '0;
                        n_cb = r_cb + CNT_Y_W'(1);
                    end else begin
                        n_ca = r_ca + CNT_X_W'(1);
                    end
                end
            end
            ST_BYTE_RD: begin
                n_bsel   = w_rem[1:0];
                n_bvalid = w_addr_ok;
            end
            ST_BYTE_SEL: begin
                case (r_bsel)
                    2'd0:    n_rdata = w_mem_rdata[23:16];
                    2'd1:    n_rdata = w_mem_rdata[15:8];
                    2'd2:    n_rdata = w_mem_rdata[7:0];
                    default: n_rdata = 8'd0;
                endcase
                if (!r_bvalid) begin
                    n_rdata = 8'd0;
                end
            end
            default: n_clr = r_clr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_ca     <= n_ca;
        r_cb     <= n_cb;
        r_lim_a  <= n_lim_a;
        r_lim_b  <= n_lim_b;
        r_gstart <= n_gstart;
        r_adv    <= n_adv;
        r_drop   <= n_drop;
        r_bad    <= n_bad;
        r_word   <= n_word;
        r_half   <= n_half;
        r_bsel   <= n_bsel;
        r_bvalid <= n_bvalid;
        r_rdata  <= n_rdata;
    end

    assign o_res.read_data = r_rdata;
    assign o_res.advance   = r_bad ? 3'd0 : r_adv;
    assign o_res.status    = r_drop ? STS_DROPPED : (r_bad ? STS_BAD_CHAR : STS_OK);

endmodule
